// ===== src/sawarq_pkg.sv =====
// Package: shared types and constants for the stop-and-wait ARQ receiver.
`timescale 1ns / 1ps
`default_nettype none

package sawarq_pkg;

  localparam int unsigned HDR_BYTES = 16;
  localparam logic [31:0] DATA_FRAME_TYPE = 32'd1;

  // Register index on the configuration port.
  localparam logic REG_MAX_PAYLOAD = 1'b0;
  localparam logic [9:0] MAX_PAYLOAD_RESET = 10'd1023;

  typedef enum logic [1:0] {
    VERDICT_DELIVERED = 2'd0,
    VERDICT_CHECKSUM  = 2'd1,
    VERDICT_DUPLICATE = 2'd2,
    VERDICT_MALFORMED = 2'd3
  } verdict_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       link_drop;
  } in_item_t;

  typedef struct packed {
    verdict_t    verdict;
    logic        ack_req;
    logic        ack_seq;
    logic [31:0] frame_sequence;
    logic [9:0]  frame_length;
  } result_t;

endpackage

`default_nettype wire

// ===== src/sawarq_cfg.sv =====
// APB-style configuration register block (max_payload).
`timescale 1ns / 1ps
`default_nettype none

module sawarq_cfg
  import sawarq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [9:0]       max_payload
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_MAX_PAYLOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RESET;
    end else if (wr_en) begin
      max_payload <= pwdata[9:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MAX_PAYLOAD) begin
      prdata = {22'd0, max_payload};
    end
  end

endmodule

`default_nettype wire

// ===== src/sawarq_in_stage.sv =====
// Input register stage: holds one accepted link byte until the core takes it.
`timescale 1ns / 1ps
`default_nettype none

module sawarq_in_stage
  import sawarq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  input  wire logic     core_ready,
  output logic          s1_valid,
  output in_item_t      s1_item
);

  logic take;
  logic advance;

  assign advance  = s1_valid && core_ready;
  assign in_stall = s1_valid && !core_ready;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_item <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== src/sawarq_core.sv =====
// Frame parser, checksum accumulator, verdict logic and result register.
`timescale 1ns / 1ps
`default_nettype none

module sawarq_core
  import sawarq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [9:0] max_payload,
  input  wire logic       s1_valid,
  input  wire in_item_t   s1_item,
  output logic            core_ready,
  output logic            res_valid,
  input  wire logic       out_stall,
  output result_t         res
);

  // Frame state
  logic        in_payload,     in_payload_next;
  logic [9:0]  byte_index,     byte_index_next;
  logic [31:0] hdr_type,       hdr_type_next;
  logic [31:0] hdr_sequence,   hdr_sequence_next;
  logic [31:0] hdr_length,     hdr_length_next;
  logic [31:0] hdr_checksum,   hdr_checksum_next;
  logic [31:0] running_sum,    running_sum_next;
  logic        expected_bit,   expected_bit_next;
  logic        last_acc_bit,   last_acc_bit_next;

  logic        fire;
  logic        emit;
  result_t     res_next;

  logic [3:0]  idx;
  logic [31:0] sum_new;
  logic [10:0] count;
  logic        judge_en;
  logic [31:0] judge_sum;
  logic [31:0] judge_chk;

  assign core_ready = !res_valid || !out_stall;
  assign fire       = s1_valid && core_ready;
  assign idx        = byte_index[3:0];
  assign sum_new    = running_sum + {24'd0, s1_item.rx_byte};
  assign count      = {1'b0, byte_index} + 11'd1;

  always_comb begin
    in_payload_next   = in_payload;
    byte_index_next   = byte_index;
    hdr_type_next     = hdr_type;
    hdr_sequence_next = hdr_sequence;
    hdr_length_next   = hdr_length;
    hdr_checksum_next = hdr_checksum;
    running_sum_next  = running_sum;
    expected_bit_next = expected_bit;
    last_acc_bit_next = last_acc_bit;
    emit              = 1'b0;
    judge_en          = 1'b0;
    judge_sum         = running_sum;
    judge_chk         = hdr_checksum;
    res_next          = '0;

    if (s1_item.link_drop) begin
      in_payload_next  = 1'b0;
      byte_index_next  = '0;
      running_sum_next = '0;
    end else if (!in_payload) begin
      // Header bytes shift into their word, big-endian.
      unique case (idx[3:2])
        2'd0:    hdr_type_next     = {hdr_type[23:0], s1_item.rx_byte};
        2'd1:    hdr_sequence_next = {hdr_sequence[23:0], s1_item.rx_byte};
        2'd2:    hdr_length_next   = {hdr_length[23:0], s1_item.rx_byte};
        default: hdr_checksum_next = {hdr_checksum[23:0], s1_item.rx_byte};
      endcase
      if (idx != 4'(HDR_BYTES - 1)) begin
        byte_index_next = {6'd0, idx + 4'd1};
      end else if (hdr_type_next != DATA_FRAME_TYPE ||
                   hdr_length_next > {22'd0, max_payload}) begin
        emit                    = 1'b1;
        res_next.verdict        = VERDICT_MALFORMED;
        res_next.ack_req        = 1'b0;
        res_next.ack_seq        = 1'b0;
        res_next.frame_sequence = hdr_sequence_next;
        res_next.frame_length   = '0;
        in_payload_next         = 1'b0;
        byte_index_next         = '0;
        running_sum_next        = '0;
      end else begin
        running_sum_next = '0;
        byte_index_next  = '0;
        if (hdr_length_next == '0) begin
          // Empty payload: judge on the last header byte.
          judge_en  = 1'b1;
          judge_sum = '0;
          judge_chk = hdr_checksum_next;
        end else begin
          in_payload_next = 1'b1;
        end
      end
    end else begin
      running_sum_next = sum_new;
      if ({21'd0, count} >= hdr_length) begin
        judge_en  = 1'b1;
        judge_sum = sum_new;
      end else begin
        byte_index_next = count[9:0];
      end
    end

    if (judge_en) begin
      emit                    = 1'b1;
      res_next.ack_req        = 1'b1;
      res_next.frame_sequence = hdr_sequence_next;
      res_next.frame_length   = hdr_length_next[9:0];
      res_next.ack_seq        = last_acc_bit;
      if (judge_sum != judge_chk) begin
        res_next.verdict = VERDICT_CHECKSUM;
      end else if (hdr_sequence_next != {31'd0, expected_bit}) begin
        res_next.verdict = VERDICT_DUPLICATE;
      end else begin
        res_next.verdict  = VERDICT_DELIVERED;
        res_next.ack_seq  = expected_bit;
        last_acc_bit_next = expected_bit;
        expected_bit_next = !expected_bit;
      end
      in_payload_next  = 1'b0;
      byte_index_next  = '0;
      running_sum_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload   <= 1'b0;
      byte_index   <= '0;
      running_sum  <= '0;
      expected_bit <= 1'b0;
      last_acc_bit <= 1'b1;
      res_valid    <= 1'b0;
    end else begin
      if (fire) begin
        in_payload   <= in_payload_next;
        byte_index   <= byte_index_next;
        running_sum  <= running_sum_next;
        expected_bit <= expected_bit_next;
        last_acc_bit <= last_acc_bit_next;
      end
      if (core_ready) begin
        res_valid <= fire && emit;
      end
    end
  end

  // Header words are fully rewritten before each use: no reset needed.
  always_ff @(posedge clk) begin
    if (fire) begin
      hdr_type     <= hdr_type_next;
      hdr_sequence <= hdr_sequence_next;
      hdr_length   <= hdr_length_next;
      hdr_checksum <= hdr_checksum_next;
    end
    if (fire && emit) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/stop_and_wait_arq_receiver_unit.sv =====
// Top level of the stop-and-wait (alternating bit) ARQ receiver.
`timescale 1ns / 1ps
`default_nettype none

// Stop-and-wait ARQ receiver. One link byte enters per transaction on the
// input channel (rx_byte, link_drop); the stream is a 16-byte big-endian
// header (type, sequence, length, checksum) followed by length payload bytes,
// which are summed modulo 2^32. At the end of each frame one result
// transaction leaves on the output channel: verdict (delivered, checksum
// mismatch, duplicate/out of order, malformed), whether to send an ACK, the
// ACK sequence bit, and the frame's sequence and length fields. Zero-length
// frames are judged on their last header byte. link_drop discards a partial
// frame and gives no result; the alternating-bit state is kept.
// Throughput: one byte per clock while in_stall is low. Each byte is folded
// into the frame state by the logic between the input register and the result register.
// A byte's result reaches the outputs through the input register and then the result register.
// The output register lets a new byte be accepted while a result waits;
// in_stall rises only while that result is held off by out_stall and the
// input register is occupied.
// max_payload sits at byte address 0 of the APB-style port (reset 1023) and
// is sampled when a frame's last header byte is processed.

module stop_and_wait_arq_receiver_unit
  import sawarq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // Input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        link_drop,
  // Output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       verdict,
  output logic             ack_req,
  output logic             ack_seq,
  output logic [31:0]      frame_sequence,
  output logic [9:0]       frame_length
);

  logic [9:0] max_payload;
  in_item_t   in_item;
  in_item_t   s1_item;
  logic       s1_valid;
  logic       core_ready;
  result_t    res;

  assign in_item.rx_byte   = rx_byte;
  assign in_item.link_drop = link_drop;

  sawarq_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .max_payload (max_payload)
  );

  sawarq_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .core_ready (core_ready),
    .s1_valid   (s1_valid),
    .s1_item    (s1_item)
  );

  sawarq_core u_core (
    .clk         (clk),
    .rst         (rst),
    .max_payload (max_payload),
    .s1_valid    (s1_valid),
    .s1_item     (s1_item),
    .core_ready  (core_ready),
    .res_valid   (out_valid),
    .out_stall   (out_stall),
    .res         (res)
  );

  assign verdict        = res.verdict;
  assign ack_req        = res.ack_req;
  assign ack_seq        = res.ack_seq;
  assign frame_sequence = res.frame_sequence;
  assign frame_length   = res.frame_length;

endmodule

`default_nettype wire

// ===== tb/stop_and_wait_arq_receiver_unit_tb.sv =====
// Testbench for the stop-and-wait ARQ receiver: byte-stream frames in, verdicts checked.
`timescale 1ns / 1ps

module stop_and_wait_arq_receiver_unit_tb;
  import sawarq_pkg::*;

  // Run-away guard, in clock cycles. The slowest legal run stays far below this.
  localparam int unsigned CYCLE_LIMIT = 800000;

  // ---------------------------------------------------------------------------
  // Frame judge: own copy of the receiver state. Every accepted input
  // transaction goes through take_byte(); each frame end queues the verdict
  // transaction the block must produce.
  // ---------------------------------------------------------------------------
  class arq_frame_judge;
    logic [9:0]  max_payload;
    logic        in_payload;
    logic [9:0]  byte_index;
    logic [31:0] hdr_type;
    logic [31:0] hdr_sequence;
    logic [31:0] hdr_length;
    logic [31:0] hdr_checksum;
    logic [31:0] running_sum;
    logic        expected_bit;
    logic        last_accepted_bit;
    result_t     pending_verdicts[$];
    int          mismatches;

    function new();
      max_payload       = MAX_PAYLOAD_RESET;
      in_payload        = 1'b0;
      byte_index        = '0;
      hdr_type          = '0;
      hdr_sequence      = '0;
      hdr_length        = '0;
      hdr_checksum      = '0;
      running_sum       = '0;
      expected_bit      = 1'b0;
      last_accepted_bit = 1'b1;
      mismatches        = 0;
    endfunction

    function void restart_frame();
      in_payload  = 1'b0;
      byte_index  = '0;
      running_sum = '0;
    endfunction

    function void post(verdict_t v, logic ack, logic aseq, logic [9:0] len);
      result_t r;
      r.verdict        = v;
      r.ack_req        = ack;
      r.ack_seq        = aseq;
      r.frame_sequence = hdr_sequence;
      r.frame_length   = len;
      pending_verdicts.push_back(r);
    endfunction

    // Well-formed frame with its payload complete.
    function void close_frame();
      if (running_sum != hdr_checksum) begin
        post(VERDICT_CHECKSUM, 1'b1, last_accepted_bit, hdr_length[9:0]);
      end else if (hdr_sequence != {31'b0, expected_bit}) begin
        // full 32-bit compare: anything but 0/1 matching the bit is a duplicate
        post(VERDICT_DUPLICATE, 1'b1, last_accepted_bit, hdr_length[9:0]);
      end else begin
        last_accepted_bit = expected_bit;
        expected_bit      = ~expected_bit;
        post(VERDICT_DELIVERED, 1'b1, last_accepted_bit, hdr_length[9:0]);
      end
      restart_frame();
    endfunction

    function void take_byte(in_item_t it);
      logic [3:0]  idx;
      int unsigned count;
      if (it.link_drop) begin
        // partial frame discarded, alternating-bit state kept
        restart_frame();
        return;
      end
      if (!in_payload) begin
        idx = byte_index[3:0];
        case (idx[3:2])
          2'd0: hdr_type = {hdr_type[23:0], it.rx_byte};
          2'd1: hdr_sequence = {hdr_sequence[23:0], it.rx_byte};
          2'd2: hdr_length = {hdr_length[23:0], it.rx_byte};
          default: hdr_checksum = {hdr_checksum[23:0], it.rx_byte};
        endcase
        if (idx != 4'(HDR_BYTES - 1)) begin
          byte_index = 10'(idx) + 10'd1;
          return;
        end
        // header done; length checked against the register as it is now
        if (hdr_type != DATA_FRAME_TYPE || hdr_length > 32'(max_payload)) begin
          post(VERDICT_MALFORMED, 1'b0, 1'b0, 10'd0);
          restart_frame();
          return;
        end
        running_sum = '0;
        byte_index  = '0;
        if (hdr_length == 0) close_frame();
        else in_payload = 1'b1;
        return;
      end
      running_sum = running_sum + 32'(it.rx_byte);
      count = 32'(byte_index) + 1;
      if (count >= hdr_length) close_frame();
      else byte_index = count[9:0];
    endfunction

    task flag_mismatch(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_verdict(result_t got);
      result_t want;
      if (pending_verdicts.size() == 0) begin
        flag_mismatch($sformatf("unexpected verdict transaction, verdict %0d seq %0h",
                                got.verdict, got.frame_sequence));
        return;
      end
      want = pending_verdicts.pop_front();
      if (got.verdict !== want.verdict)
        flag_mismatch($sformatf("verdict got %0d want %0d", got.verdict, want.verdict));
      if (got.ack_req !== want.ack_req)
        flag_mismatch($sformatf("ack_req got %0b want %0b", got.ack_req, want.ack_req));
      if (got.ack_seq !== want.ack_seq)
        flag_mismatch($sformatf("ack_seq got %0b want %0b", got.ack_seq, want.ack_seq));
      if (got.frame_sequence !== want.frame_sequence)
        flag_mismatch($sformatf("frame_sequence got %0h want %0h",
                                got.frame_sequence, want.frame_sequence));
      if (got.frame_length !== want.frame_length)
        flag_mismatch($sformatf("frame_length got %0d want %0d",
                                got.frame_length, want.frame_length));
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // DUT signals; every input known from time zero
  // ---------------------------------------------------------------------------
  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte   = '0;
  logic        link_drop = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  verdict;
  logic        ack_req;
  logic        ack_seq;
  logic [31:0] frame_sequence;
  logic [9:0]  frame_length;

  arq_frame_judge board;
  in_item_t       byte_stream[$];   // input transactions waiting to be driven
  int             data_bytes  = 0;  // accepted bytes that were not link drops
  bit             feed_gaps   = 1'b0;
  bit             sink_gaps   = 1'b0;
  int             stall_left  = 0;
  int unsigned    cycle_count = 0;

  stop_and_wait_arq_receiver_unit dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .link_drop     (link_drop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .verdict       (verdict),
    .ack_req       (ack_req),
    .ack_seq       (ack_seq),
    .frame_sequence(frame_sequence),
    .frame_length  (frame_length)
  );

  always #5 clk = ~clk;

  // Timeout: a lost or never-arriving verdict ends up here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("stop_and_wait_arq_receiver_unit: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: sample the transaction at the edge (pre-update values), then
  // pick the stall for the next cycle.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : sink
    result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.verdict        = verdict_t'(verdict);
      got.ack_req        = ack_req;
      got.ack_seq        = ack_seq;
      got.frame_sequence = frame_sequence;
      got.frame_length   = frame_length;
      board.check_verdict(got);
    end
    if (stall_left == 0 && sink_gaps && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 12);
    out_stall <= (stall_left > 0);
    if (stall_left > 0) stall_left--;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Payload bytes lean on the extremes now and then.
  function automatic logic [7:0] payload_byte();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 8'h00;
    if (roll == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic in_item_t drop_item();
    return '{rx_byte: 8'($urandom), link_drop: 1'b1};
  endfunction

  // Header fields go out big-endian.
  function automatic void push_word(logic [31:0] w);
    for (int k = 3; k >= 0; k--)
      byte_stream.push_back('{rx_byte: w[8*k +: 8], link_drop: 1'b0});
  endfunction

  // Drive up to count queued transactions. Valid stays high between items, except
  // during random feed gaps, so it never gets two updates in one step; the last payload
  // just sits there until the next call or settle() drops valid.
  task automatic drive_stream(input int count);
    in_item_t item;
    for (int i = 0; i < count && byte_stream.size() > 0; i++) begin
      if (feed_gaps && $urandom_range(0, 9) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      item = byte_stream.pop_front();
      in_valid  <= 1'b1;
      rx_byte   <= item.rx_byte;
      link_drop <= item.link_drop;
      do @(posedge clk); while (in_stall);
      board.take_byte(item);
      if (!item.link_drop) data_bytes++;
    end
  endtask

  // Wait for the block to go quiet: all verdicts in, then a wait so that bytes
  // that cause no verdict leave the input register.
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write at a quiet point: setup cycle, then access cycle.
  task automatic write_max_payload(input logic [9:0] value);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_MAX_PAYLOAD, 2'b00};
    pwdata  <= {22'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.max_payload = value;
  endtask

  // One frame. Payload only follows a header that is well formed against the
  // current register value. skew spoils the checksum; cut >= 0 aborts the
  // frame with a link drop after that many bytes; hold >= 0 drives only the
  // first hold bytes and leaves the rest queued.
  task automatic send_frame(input logic [31:0] ftype, input logic [31:0] seq,
                            input logic [31:0] len, input logic [31:0] skew,
                            input int cut, input int hold);
    logic [7:0]  body[$];
    logic [31:0] sum;
    int          start;
    sum   = '0;
    start = byte_stream.size();
    if (ftype == DATA_FRAME_TYPE && len <= 32'(board.max_payload)) begin
      repeat (int'(len)) begin
        body.push_back(payload_byte());
        sum += 32'(body[$]);
      end
    end
    push_word(ftype);
    push_word(seq);
    push_word(len);
    push_word(sum + skew);
    foreach (body[k]) byte_stream.push_back('{rx_byte: body[k], link_drop: 1'b0});
    if (cut >= 0 && start + cut < byte_stream.size()) begin
      while (byte_stream.size() > start + cut) void'(byte_stream.pop_back());
      byte_stream.push_back(drop_item());
    end
    drive_stream(hold >= 0 ? hold : byte_stream.size());
  endtask

  // Mostly good frames with random content; some bad type, wrong sequence,
  // over-long length, bad checksum or aborted midway.
  task automatic random_frame();
    logic [31:0] ftype;
    logic [31:0] seq;
    logic [31:0] len;
    logic [31:0] skew;
    int          roll;
    int          cut;
    int unsigned cap;
    ftype = DATA_FRAME_TYPE;
    roll  = $urandom_range(0, 99);
    if (roll < 3) ftype = 32'($urandom);
    else if (roll < 5) ftype = 32'd0;
    else if (roll < 7) ftype = 32'h0100_0001;
    else if (roll < 8) ftype = 32'hFFFF_FFFF;

    roll = $urandom_range(0, 99);
    if (roll < 60) seq = {31'b0, board.expected_bit};
    else if (roll < 82) seq = {31'b0, ~board.expected_bit};
    else if (roll < 92) seq = 32'($urandom);
    else seq = {31'($urandom_range(1, 32'h7FFF_FFFF)), board.expected_bit};

    cap  = (board.max_payload < 10'd24) ? 32'(board.max_payload) : 24;
    roll = $urandom_range(0, 99);
    if (roll < 84 || (roll < 89 && board.max_payload > 10'd256))
      len = $urandom_range(0, cap);
    else if (roll < 89) len = 32'(board.max_payload);
    else if (roll < 96) len = 32'(board.max_payload) + 1 + $urandom_range(0, 15);
    else len = 32'($urandom) | 32'h0000_0400;

    skew = ($urandom_range(0, 99) < 15) ? 32'($urandom_range(1, 32'hFFFF_FFFF)) : 32'd0;
    cut  = -1;
    if ($urandom_range(0, 99) < 6)
      cut = $urandom_range(0, 15 + ((len <= 32'(board.max_payload)) ? int'(len) : 0));
    send_frame(ftype, seq, len, skew, cut, -1);
  endtask

  // Line noise: random bytes, then a link drop to realign the parser.
  task automatic spray_noise();
    repeat ($urandom_range(1, 20))
      byte_stream.push_back('{rx_byte: 8'($urandom), link_drop: 1'b0});
    byte_stream.push_back(drop_item());
    drive_stream(byte_stream.size());
  endtask

  task automatic random_phase(input int goal);
    int first;
    first = data_bytes;
    while (data_bytes - first < goal) begin
      if ($urandom_range(0, 99) < 5) spray_noise();
      else random_frame();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : run
    int unsigned caps[7];
    caps  = '{0, 24, 1023, 5, 0, 1, 1023};
    board = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    feed_gaps = 1'b1;
    sink_gaps = 1'b1;

    // Directed frames, register at its reset value (1023).
    send_frame(DATA_FRAME_TYPE, 32'd0, 32'd0, 32'd0, -1, -1);         // zero length, delivered
    send_frame(DATA_FRAME_TYPE, 32'd0, 32'd0, 32'd0, -1, -1);         // same bit again: duplicate
    send_frame(DATA_FRAME_TYPE, 32'd1, 32'd3, 32'd0, -1, -1);         // delivered
    send_frame(DATA_FRAME_TYPE, 32'd0, 32'd2, 32'hFFFF_FFFF, -1, -1); // checksum mismatch
    send_frame(32'd2, 32'd0, 32'd0, 32'd0, -1, -1);                   // bad type
    send_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd5, 32'd0, -1, -1);
    send_frame(DATA_FRAME_TYPE, 32'h0000_0100, 32'd0, 32'd0, -1, -1); // upper seq bits set
    send_frame(DATA_FRAME_TYPE, 32'd0, 32'd1024, 32'd0, -1, -1);      // one past the limit
    send_frame(DATA_FRAME_TYPE, 32'd0, 32'hFFFF_FFFF, 32'd0, -1, -1);
    send_frame(DATA_FRAME_TYPE, 32'd0, 32'd4, 32'd0, 7, -1);          // drop inside header
    send_frame(DATA_FRAME_TYPE, 32'd0, 32'd6, 32'd0, 19, -1);         // drop inside payload
    send_frame(DATA_FRAME_TYPE, {31'b0, board.expected_bit}, 32'd2, 32'd0, -1, -1);
    send_frame(DATA_FRAME_TYPE, {31'b0, board.expected_bit}, 32'd57, 32'd0, -1, -1);

    // Register changed with a header half received: the new value applies.
    send_frame(DATA_FRAME_TYPE, {31'b0, board.expected_bit}, 32'd8, 32'd0, -1, 10);
    write_max_payload(10'd7);
    drive_stream(byte_stream.size());   // now malformed; payload spills into parser
    byte_stream.push_back(drop_item());
    drive_stream(byte_stream.size());
    send_frame(DATA_FRAME_TYPE, {31'b0, board.expected_bit}, 32'd6, 32'd0, -1, 5);
    write_max_payload(10'd6);
    drive_stream(byte_stream.size());   // length equals the limit: accepted

    // Random phases across several limits; last one with no idling at all.
    for (int p = 0; p < 7; p++) begin
      write_max_payload((p == 4) ? 10'($urandom_range(2, 1022)) : 10'(caps[p]));
      feed_gaps = (p != 2 && p != 6);
      sink_gaps = feed_gaps;
      random_phase(140);
    end

    settle();
    repeat (8) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("stop_and_wait_arq_receiver_unit: match");
    end else begin
      $display("stop_and_wait_arq_receiver_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== stop_and_wait_arq_receiver_unit.f =====
src/sawarq_pkg.sv
src/sawarq_cfg.sv
src/sawarq_in_stage.sv
src/sawarq_core.sv
src/stop_and_wait_arq_receiver_unit.sv
tb/stop_and_wait_arq_receiver_unit_tb.sv
